FILE: src/assert_macros.svh
// Assertion macros used by the checker module smeu_checker.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/smeu_pkg.sv
// Package for the stack machine execute unit: sizes, codes, types.
// Depends on nothing.
`default_nettype none
package smeu_pkg;
  localparam int StackDepth   = 256;
  localparam int VarCount     = 16;
  localparam int ProgramDepth = 4096;
  localparam int SpW          = $clog2(StackDepth);
  localparam int LvW          = $clog2(StackDepth + 1);
  localparam int ViW          = 4;

  typedef enum logic [4:0] {
    F_PUSH = 5'd0, F_POP = 5'd1, F_ABS = 5'd2, F_DUP = 5'd3, F_SWAP = 5'd4,
    F_OVER = 5'd5, F_ROT = 5'd6, F_ADD = 5'd7, F_SUB = 5'd8, F_MUL = 5'd9,
    F_DIV = 5'd10, F_MOD = 5'd11, F_READ = 5'd12, F_BRANCH = 5'd13,
    F_GET = 5'd14, F_SETVAR = 5'd15, F_TOP = 5'd16
  } func_t;

  typedef enum logic [2:0] {
    C_LT = 3'd0, C_GT = 3'd1, C_EQ = 3'd2, C_GE = 3'd3, C_LE = 3'd4, C_NE = 3'd5
  } cmp_t;

  localparam logic [1:0] ST_OK = 2'd0, ST_OVER = 2'd1, ST_UNDER = 2'd2, ST_DIVZ = 2'd3;
endpackage
`default_nettype wire

FILE: src/stack_machine_execute_unit_core.sv
// Top level of the stack machine execute unit.
// Depends on smeu_pkg.
//
// One instruction at a time. The stack lives in a one-port-read synchronous RAM.
// Up to three top entries are read in states S_RD1, S_RD2 and S_RD3, and the changed
// entries are written back in S_WR1, S_WR2 and S_WR3. Mul adds the state S_MUL for
// its registered product. Div/mod with a nonzero divisor add the state S_DIV, a
// one-bit-per-cycle restoring divider. A new input is taken only once the previous
// result has been transferred out.
`default_nettype none
module stack_machine_execute_unit_core
  import smeu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         in_func,
  input  wire logic signed [31:0] in_operand_value,
  input  wire logic [2:0]         in_compare_kind,
  input  wire logic [3:0]         in_var_index,
  input  wire logic [11:0]        in_jump_target,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_top_value,
  output logic [8:0]              out_stack_level,
  output logic                    out_branch_taken,
  output logic [11:0]             out_branch_dest,
  output logic                    out_report_valid,
  output logic [1:0]              out_status
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_MUL, S_DIV, S_WR1, S_WR2, S_WR3, S_DONE
  } state_t;

  logic [31:0] mem [StackDepth];
  logic [31:0] vars_r [VarCount];
  logic [VarCount-1:0] vvalid_r;
  logic [31:0] rdata_r;

  state_t state_r;
  logic [LvW-1:0] lv_r;
  logic [4:0] f_r;
  logic [31:0] opv_r;
  logic [2:0] kind_r;
  logic [ViW-1:0] vi_r;
  logic [11:0] tgt_r;
  logic [31:0] a_r, b_r;
  logic [1:0] nrd_r, cnt_r;
  logic [31:0] w_r [3];
  logic [SpW-1:0] wa_r [3];
  logic [1:0] nwr_r;
  logic [LvW-1:0] newlv_r;
  logic [31:0] newtop_r;
  logic [31:0] prod_r;
  logic [31:0] dq_r, drem_r, dvs_r;
  logic [5:0] dcnt_r;
  logic dnq_r, dnr_r;

  logic [LvW-1:0] needs, grows;
  logic [SpW-1:0] rd_addr;
  logic           rd_en;

  logic [1:0]     st_nxt;
  logic           taken_nxt, rep_nxt;
  logic [11:0]    dest_nxt;
  logic [1:0]     nwr_nxt;
  logic [LvW-1:0] newlv_nxt;
  logic [31:0]    newtop_nxt;
  logic [31:0]    w_nxt [3];
  logic [SpW-1:0] wa_nxt [3];
  state_t         exec_nxt;
  logic           var_we;
  logic [31:0]    get_val, addsub;

  always_comb begin
    needs = '0;
    grows = '0;
    case (f_r)
      F_POP, F_ABS, F_DUP, F_BRANCH, F_SETVAR, F_TOP: needs = LvW'(1);
      F_SWAP, F_OVER, F_ADD, F_SUB, F_MUL, F_DIV, F_MOD: needs = LvW'(2);
      F_ROT: needs = LvW'(3);
      default: needs = '0;
    endcase
    case (f_r)
      F_PUSH, F_DUP, F_OVER, F_READ, F_GET: grows = LvW'(1);
      default: grows = '0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (state_r == S_RD1 || state_r == S_RD2 || state_r == S_RD3) begin
      rd_en = (cnt_r < nrd_r);
      rd_addr = SpW'(lv_r - LvW'(cnt_r) - LvW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
    if (state_r == S_WR1 || state_r == S_WR2 || state_r == S_WR3) begin
      if (cnt_r < nwr_r) mem[wa_r[cnt_r]] <= w_r[cnt_r];
    end
  end

  logic signed [31:0] sa, sb, sv;
  logic hit;
  logic [32:0] dtrial;
  assign sa = $signed(a_r);
  assign sb = $signed(b_r);
  assign sv = $signed(opv_r);
  assign dtrial = {drem_r, dq_r[31]} - {1'b0, dvs_r};

  always_comb begin
    case (kind_r)
      C_LT: hit = sa < sv;
      C_GT: hit = sa > sv;
      C_EQ: hit = sa == sv;
      C_GE: hit = sa >= sv;
      C_LE: hit = sa <= sv;
      C_NE: hit = sa != sv;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt     = ST_OK;
    taken_nxt  = 1'b0;
    dest_nxt   = '0;
    rep_nxt    = 1'b0;
    nwr_nxt    = '0;
    newlv_nxt  = lv_r;
    newtop_nxt = a_r;
    exec_nxt   = S_WR1;
    var_we     = 1'b0;
    w_nxt[0]   = '0;
    w_nxt[1]   = '0;
    w_nxt[2]   = '0;
    wa_nxt[0]  = '0;
    wa_nxt[1]  = '0;
    wa_nxt[2]  = '0;
    get_val = (int'(vi_r) < VarCount && vvalid_r[vi_r]) ? vars_r[vi_r] : '0;
    addsub = (f_r == F_ADD) ? b_r + a_r : b_r - a_r;
    if (lv_r < needs) st_nxt = ST_UNDER;
    else if ((lv_r + grows) > LvW'(StackDepth)) st_nxt = ST_OVER;
    else begin
      case (f_r)
        F_PUSH, F_READ: begin
          w_nxt[0] = opv_r; wa_nxt[0] = SpW'(lv_r); nwr_nxt = 2'd1;
          newlv_nxt = lv_r + LvW'(1); newtop_nxt = opv_r;
        end
        F_POP: begin newlv_nxt = lv_r - LvW'(1); newtop_nxt = b_r; end
        F_ABS: if (a_r[31]) begin
          w_nxt[0] = 32'd0 - a_r; wa_nxt[0] = SpW'(lv_r - LvW'(1));
          nwr_nxt = 2'd1; newtop_nxt = 32'd0 - a_r;
        end
        F_DUP: begin
          w_nxt[0] = a_r; wa_nxt[0] = SpW'(lv_r); nwr_nxt = 2'd1;
          newlv_nxt = lv_r + LvW'(1);
        end
        F_SWAP: begin
          w_nxt[0] = b_r; wa_nxt[0] = SpW'(lv_r - LvW'(1));
          w_nxt[1] = a_r; wa_nxt[1] = SpW'(lv_r - LvW'(2));
          nwr_nxt = 2'd2; newtop_nxt = b_r;
        end
        F_OVER: begin
          w_nxt[0] = b_r; wa_nxt[0] = SpW'(lv_r); nwr_nxt = 2'd1;
          newlv_nxt = lv_r + LvW'(1); newtop_nxt = b_r;
        end
        F_ROT: begin
          w_nxt[0] = b_r; wa_nxt[0] = SpW'(lv_r - LvW'(3));
          w_nxt[1] = a_r; wa_nxt[1] = SpW'(lv_r - LvW'(2));
          w_nxt[2] = rdata_r; wa_nxt[2] = SpW'(lv_r - LvW'(1));
          nwr_nxt = 2'd3; newtop_nxt = rdata_r;
        end
        F_ADD, F_SUB: begin
          w_nxt[0] = addsub; newtop_nxt = addsub;
          wa_nxt[0] = SpW'(lv_r - LvW'(2)); nwr_nxt = 2'd1;
          newlv_nxt = lv_r - LvW'(1);
        end
        F_MUL: begin
          wa_nxt[0] = SpW'(lv_r - LvW'(2)); nwr_nxt = 2'd1;
          newlv_nxt = lv_r - LvW'(1);
          exec_nxt = S_MUL;
        end
        F_DIV, F_MOD: begin
          if (a_r == 32'd0) st_nxt = ST_DIVZ;
          else begin
            wa_nxt[0] = SpW'(lv_r - LvW'(2)); nwr_nxt = 2'd1;
            newlv_nxt = lv_r - LvW'(1);
            exec_nxt = S_DIV;
          end
        end
        F_BRANCH: if (hit) begin
          taken_nxt = 1'b1;
          dest_nxt = (int'(tgt_r) < ProgramDepth) ? tgt_r : 12'(ProgramDepth - 1);
        end
        F_GET: begin
          w_nxt[0] = get_val; newtop_nxt = get_val;
          wa_nxt[0] = SpW'(lv_r); nwr_nxt = 2'd1;
          newlv_nxt = lv_r + LvW'(1);
        end
        F_SETVAR: var_we = (int'(vi_r) < VarCount);
        F_TOP: rep_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lv_r <= '0;
      out_valid <= 1'b0;
      vvalid_r <= '0;
    end else begin
      if (state_r == S_DONE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            f_r <= in_func;
            opv_r <= in_operand_value;
            kind_r <= in_compare_kind;
            vi_r <= in_var_index;
            tgt_r <= in_jump_target;
            cnt_r <= '0;
            a_r <= '0; b_r <= '0;
            nrd_r <= (lv_r >= LvW'(3)) ? 2'd3 : 2'(lv_r);
            state_r <= S_RD1;
          end
        end
        S_RD1: begin cnt_r <= cnt_r + 2'd1; state_r <= S_RD2; end
        S_RD2: begin
          if (nrd_r >= 2'd1) a_r <= rdata_r;
          cnt_r <= cnt_r + 2'd1; state_r <= S_RD3;
        end
        S_RD3: begin
          if (nrd_r >= 2'd2) b_r <= rdata_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_status <= st_nxt;
          out_branch_taken <= taken_nxt;
          out_branch_dest <= dest_nxt;
          out_report_valid <= rep_nxt;
          nwr_r <= nwr_nxt;
          cnt_r <= '0;
          newlv_r <= newlv_nxt;
          newtop_r <= newtop_nxt;
          w_r[0] <= w_nxt[0]; w_r[1] <= w_nxt[1]; w_r[2] <= w_nxt[2];
          wa_r[0] <= wa_nxt[0]; wa_r[1] <= wa_nxt[1]; wa_r[2] <= wa_nxt[2];
          prod_r <= b_r * a_r;
          dq_r <= b_r[31] ? 32'd0 - b_r : b_r;
          dvs_r <= a_r[31] ? 32'd0 - a_r : a_r;
          drem_r <= '0;
          dcnt_r <= '0;
          dnq_r <= a_r[31] ^ b_r[31];
          dnr_r <= b_r[31];
          if (var_we) begin
            vars_r[vi_r] <= a_r; vvalid_r[vi_r] <= 1'b1;
          end
          state_r <= exec_nxt;
        end
        S_MUL: begin
          w_r[0] <= prod_r; newtop_r <= prod_r;
          state_r <= S_WR1;
        end
        S_DIV: begin
          if (dcnt_r == 6'd32) begin
            w_r[0] <= (f_r == F_DIV) ? (dnq_r ? 32'd0 - dq_r : dq_r)
                                     : (dnr_r ? 32'd0 - drem_r : drem_r);
            newtop_r <= (f_r == F_DIV) ? (dnq_r ? 32'd0 - dq_r : dq_r)
                                       : (dnr_r ? 32'd0 - drem_r : drem_r);
            state_r <= S_WR1;
          end else begin
            dcnt_r <= dcnt_r + 6'd1;
            if (!dtrial[32]) begin
              drem_r <= dtrial[31:0];
              dq_r <= {dq_r[30:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dq_r[31]};
              dq_r <= {dq_r[30:0], 1'b0};
            end
          end
        end
        S_WR1: begin cnt_r <= cnt_r + 2'd1; state_r <= S_WR2; end
        S_WR2: begin cnt_r <= cnt_r + 2'd1; state_r <= S_WR3; end
        S_WR3: state_r <= S_DONE;
        S_DONE: begin
          lv_r <= newlv_r;
          out_stack_level <= 9'(newlv_r);
          out_top_value <= (newlv_r == '0) ? '0 : newtop_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/smeu_checker.sv
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on smeu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module smeu_checker
  import smeu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [8:0]  out_stack_level,
  input wire logic        out_branch_taken,
  input wire logic        out_report_valid,
  input wire logic [1:0]  out_status
);
  `ASSERT_IMPL(a_level_max, clk, rst_n, out_valid, out_stack_level <= 9'(StackDepth))
  `ASSERT_IMPL(a_err_quiet, clk, rst_n, out_valid && out_status != ST_OK, !out_branch_taken && !out_report_valid)
  `ASSERT_IMPL(a_one_hot_flags, clk, rst_n, out_valid, !(out_branch_taken && out_report_valid))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_accept_free, clk, rst_n, in_valid && in_ready, !out_valid || out_ready)
endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (.*);
`default_nettype wire

FILE: verif/stack_machine_execute_unit_core_test.sv
// Testbench for stack_machine_execute_unit_core: directed and random instruction streams,
// each result checked against a scoreboard that predicts stack, variables and flags.
// Depends on smeu_pkg and the core RTL.
module stack_machine_execute_unit_core_test;
  import smeu_pkg::*;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [8:0]         stack_level;
    logic               branch_taken;
    logic [11:0]        branch_dest;
    logic               report_valid;
    logic [1:0]         status;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0]  stack_mem [StackDepth];
    logic [31:0]  var_mem [VarCount];
    int           depth;
    exec_result_t expected_q [$];
    int           n_in, n_out, n_err;
    int           n_status [4];

    function new();
      depth = 0;
      foreach (var_mem[i]) var_mem[i] = '0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function int needs(logic [4:0] f);
      case (f)
        F_POP, F_ABS, F_DUP, F_BRANCH, F_SETVAR, F_TOP: return 1;
        F_SWAP, F_OVER, F_ADD, F_SUB, F_MUL, F_DIV, F_MOD: return 2;
        F_ROT: return 3;
        default: return 0;
      endcase
    endfunction

    function int grows(logic [4:0] f);
      return (f == F_PUSH || f == F_DUP || f == F_OVER || f == F_READ || f == F_GET);
    endfunction

    function void note(logic [4:0] f, logic [31:0] opv, logic [2:0] kind, logic [3:0] vi,
                       logic [11:0] tgt);
      exec_result_t r;
      logic [31:0] a, b, c;
      logic signed [31:0] t, v;
      longint q, m;
      logic hit;
      int lv;
      lv = depth;
      r = '0;
      a = 0; b = 0; c = 0;
      n_in++;
      if (lv < needs(f)) begin
        r.status = ST_UNDER;
      end else if (lv + grows(f) > StackDepth) begin
        r.status = ST_OVER;
      end else begin
        if (lv >= 1) a = stack_mem[lv-1];
        if (lv >= 2) b = stack_mem[lv-2];
        if (lv >= 3) c = stack_mem[lv-3];
        case (f)
          F_PUSH, F_READ: begin stack_mem[lv] = opv; lv++; end
          F_POP: lv--;
          F_ABS: if (a[31]) stack_mem[lv-1] = 32'd0 - a;
          F_DUP: begin stack_mem[lv] = a; lv++; end
          F_SWAP: begin stack_mem[lv-1] = b; stack_mem[lv-2] = a; end
          F_OVER: begin stack_mem[lv] = b; lv++; end
          F_ROT: begin stack_mem[lv-3] = b; stack_mem[lv-2] = a; stack_mem[lv-1] = c; end
          F_ADD: begin stack_mem[lv-2] = b + a; lv--; end
          F_SUB: begin stack_mem[lv-2] = b - a; lv--; end
          F_MUL: begin stack_mem[lv-2] = b * a; lv--; end
          F_DIV, F_MOD: begin
            if (a == 0) begin
              r.status = ST_DIVZ;
            end else begin
              q = longint'($signed(b)) / longint'($signed(a));
              m = longint'($signed(b)) % longint'($signed(a));
              stack_mem[lv-2] = (f == F_DIV) ? q[31:0] : m[31:0];
              lv--;
            end
          end
          F_BRANCH: begin
            t = a; v = opv;
            case (kind)
              C_LT: hit = t < v;
              C_GT: hit = t > v;
              C_EQ: hit = t == v;
              C_GE: hit = t >= v;
              C_LE: hit = t <= v;
              C_NE: hit = t != v;
              default: hit = 1'b0;
            endcase
            if (hit) begin
              r.branch_taken = 1'b1;
              r.branch_dest = (tgt < ProgramDepth) ? tgt : 12'(ProgramDepth - 1);
            end
          end
          F_GET: begin stack_mem[lv] = (vi < VarCount) ? var_mem[vi] : 32'd0; lv++; end
          F_SETVAR: if (vi < VarCount) var_mem[vi] = a;
          F_TOP: r.report_valid = 1'b1;
          default: ;
        endcase
        depth = lv;
      end
      r.top_value = lv ? stack_mem[lv-1] : 32'd0;
      r.stack_level = 9'(lv);
      n_status[r.status]++;
      expected_q = {expected_q, r};
    endfunction

    function void check(exec_result_t got);
      exec_result_t e;
      n_out++;
      if (expected_q.size() == 0) begin
        $error("result with no expectation pending");
        n_err++;
        return;
      end
      e = expected_q.pop_front();
      if (got.top_value !== e.top_value) begin
        $error("top_value exp %0d got %0d", e.top_value, got.top_value); n_err++;
      end
      if (got.stack_level !== e.stack_level) begin
        $error("stack_level exp %0d got %0d", e.stack_level, got.stack_level); n_err++;
      end
      if (got.branch_taken !== e.branch_taken) begin
        $error("branch_taken exp %0d got %0d", e.branch_taken, got.branch_taken); n_err++;
      end
      if (got.branch_dest !== e.branch_dest) begin
        $error("branch_dest exp %0d got %0d", e.branch_dest, got.branch_dest); n_err++;
      end
      if (got.report_valid !== e.report_valid) begin
        $error("report_valid exp %0d got %0d", e.report_valid, got.report_valid); n_err++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); n_err++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [4:0]         in_func;
  logic signed [31:0] in_operand_value;
  logic [2:0]         in_compare_kind;
  logic [3:0]         in_var_index;
  logic [11:0]        in_jump_target;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_top_value;
  logic [8:0]         out_stack_level;
  logic               out_branch_taken;
  logic [11:0]        out_branch_dest;
  logic               out_report_valid;
  logic [1:0]         out_status;

  exec_scoreboard sb;
  logic           long_hold_done;

  stack_machine_execute_unit_core u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_operand_value, .in_compare_kind,
    .in_var_index, .in_jump_target, .out_valid, .out_ready, .out_top_value,
    .out_stack_level, .out_branch_taken, .out_branch_dest, .out_report_valid, .out_status
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("tb: failure");
    $finish;
  end

  task automatic send_instr(logic [4:0] f, logic [31:0] opv, logic [2:0] kind,
                            logic [3:0] vi, logic [11:0] tgt);
    in_valid         <= 1'b1;
    in_func          <= f;
    in_operand_value <= opv;
    in_compare_kind  <= kind;
    in_var_index     <= vi;
    in_jump_target   <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(f, opv, kind, vi, tgt);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4, 5: return 32'($signed($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_func(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 5'($urandom_range(17, 31));
    if (filling && r < 60) begin
      case ($urandom_range(0, 4))
        0: return F_PUSH;
        1: return F_READ;
        2: return F_GET;
        3: return F_DUP;
        default: return F_OVER;
      endcase
    end
    if (!filling && r < 45) begin
      case ($urandom_range(0, 6))
        0: return F_POP;
        1: return F_ADD;
        2: return F_SUB;
        3: return F_MUL;
        4: return F_DIV;
        5: return F_MOD;
        default: return F_POP;
      endcase
    end
    return 5'($urandom_range(0, 16));
  endfunction

  task automatic directed_part();
    send_instr(F_POP, 0, 0, 0, 0);
    send_instr(F_ROT, 0, 0, 0, 0);
    send_instr(F_PUSH, 32'h8000_0000, 0, 0, 0);
    send_instr(F_ABS, 0, 0, 0, 0);
    send_instr(F_PUSH, 32'hffff_ffff, 0, 0, 0);
    send_instr(F_OVER, 0, 0, 0, 0);
    send_instr(F_OVER, 0, 0, 0, 0);
    send_instr(F_ROT, 0, 0, 0, 0);
    send_instr(F_MOD, 0, 0, 0, 0);
    send_instr(F_READ, 32'hffff_ffff, 0, 0, 0);
    send_instr(F_DIV, 0, 0, 0, 0);
    send_instr(F_SETVAR, 0, 0, 4'd15, 0);
    send_instr(F_READ, 0, 0, 0, 0);
    send_instr(F_DIV, 0, 0, 0, 0);
    send_instr(F_SWAP, 0, 0, 0, 0);
    send_instr(F_GET, 0, 0, 4'd15, 0);
    send_instr(F_MUL, 0, 0, 0, 0);
    for (int k = 0; k < 8; k++) send_instr(F_BRANCH, 32'h7fff_ffff, 3'(k), 0, 12'hfff);
    send_instr(F_TOP, 0, 0, 0, 0);
    send_instr(5'd31, $urandom, 3'd7, 4'd15, 12'hfff);
  endtask

  initial begin
    int gap, burst;
    bit filling;
    sb = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= '0;
    in_operand_value <= '0;
    in_compare_kind  <= '0;
    in_var_index     <= '0;
    in_jump_target   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    filling = 1'b1;
    for (int n = 0; n < 1100;) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        if ((n % 350) == 0) filling = ~filling ^ (n == 0);
        send_instr(rand_func(filling), rand_operand(), 3'($urandom_range(0, 7)),
                   4'($urandom), 12'($urandom));
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_gap(gap);
    end
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("run: %0d instructions, %0d results; ok %0d, overflow %0d, underflow %0d, divz %0d",
             sb.n_in, sb.n_out, sb.n_status[ST_OK], sb.n_status[ST_OVER],
             sb.n_status[ST_UNDER], sb.n_status[ST_DIVZ]);
    if (sb.n_err == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int mode, cyc, hold;
    exec_result_t got;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    mode = 0;
    cyc = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.top_value    = out_top_value;
        got.stack_level  = out_stack_level;
        got.branch_taken = out_branch_taken;
        got.branch_dest  = out_branch_dest;
        got.report_valid = out_report_valid;
        got.status       = out_status;
        sb.check(got);
      end
      cyc++;
      if ((cyc % 64) == 0) mode = $urandom_range(0, 2);
      if (!long_hold_done && sb.n_in >= 400) begin
        long_hold_done = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end
endmodule
